// ----- src/kla_pkg.sv -----
// Shared types and constants for the keyword line alarm.
// Holds the keyword table, register word indexes and the result structs.
`default_nettype none

package kla_pkg;

  localparam int LINE_MAX_DEF     = 512;
  localparam int WINDOW_BYTES_DEF = 15;

  localparam int KW_COUNT   = 10;
  localparam int KW_MAX_LEN = 15;

  localparam logic [7:0] NEWLINE_CHAR = 8'h0A;
  localparam logic [7:0] NUL_CHAR     = 8'h00;

  // ASCII keyword bytes; last character of each keyword sits in the lowest byte.
  localparam logic [KW_MAX_LEN*8-1:0] KW_TEXT [KW_COUNT] = '{
    (KW_MAX_LEN*8)'(88'h677265656e5f6d616d6261),
    (KW_MAX_LEN*8)'(96'h686f726e65645f7669706572),
    (KW_MAX_LEN*8)'(120'h626f615f636f6e7374726963746f72),
    (KW_MAX_LEN*8)'(96'h6761727465725f736e616b65),
    (KW_MAX_LEN*8)'(72'h7365615f736e616b65),
    (KW_MAX_LEN*8)'(88'h6469616d6f6e646261636b),
    (KW_MAX_LEN*8)'(96'h496e6469616e5f636f627261),
    (KW_MAX_LEN*8)'(88'h677265656e5f736e616b65),
    (KW_MAX_LEN*8)'(88'h726f636b5f707974686f6e),
    (KW_MAX_LEN*8)'(96'h62616e6465645f6b72616974)
  };

  localparam logic [4:0] KW_LEN [KW_COUNT] = '{
    5'd11, 5'd12, 5'd15, 5'd12, 5'd9, 5'd11, 5'd12, 5'd11, 5'd11, 5'd12
  };

  localparam logic [15:0] BUZZ_MS_RESET = 16'd1000;
  localparam logic [15:0] MUTE_MS_RESET = 16'd3000;
  localparam logic [15:0] ELAPSED_MAX   = 16'hFFFF;

  localparam int          PADDR_W     = 3;
  localparam logic        REG_BUZZ_MS = 1'b0;
  localparam logic        REG_MUTE_MS = 1'b1;

  typedef struct packed {
    logic byte_go;
    logic tick_go;
  } step_t;

  typedef struct packed {
    logic ended;
    logic matched;
    logic dropped;
  } line_res_t;

  typedef struct packed {
    logic pin;
    logic started;
    logic muted;
  } alarm_res_t;

endpackage

`default_nettype wire

// ----- src/kla_line.sv -----
// Line scanner: byte window, line length, cut and keyword flags.
// Depends on kla_pkg for the keyword table and result struct.
`default_nettype none

module kla_line
  import kla_pkg::*;
#(
  parameter int LINE_MAX     = LINE_MAX_DEF,
  parameter int WINDOW_BYTES = WINDOW_BYTES_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire step_t      step,
  input  wire logic [7:0] byte_value,
  output line_res_t       res
);

  localparam int LEN_W = $clog2(LINE_MAX);
  localparam logic [LEN_W-1:0] LEN_LIMIT = LEN_W'(LINE_MAX - 1);

  logic [7:0]       win [WINDOW_BYTES];
  logic [7:0]       win_sh [WINDOW_BYTES];
  logic [LEN_W-1:0] line_length;
  logic             text_cut;
  logic             keyword_seen;

  logic             room;
  logic             is_newline;
  logic             cut_next;
  logic             hit;
  logic             clear_line;

  always_comb begin
    for (int i = 0; i < WINDOW_BYTES - 1; i++) begin
      win_sh[i] = win[i+1];
    end
    win_sh[WINDOW_BYTES-1] = byte_value;
  end

  always_comb begin
    logic kw_ok;
    hit = 1'b0;
    for (int k = 0; k < KW_COUNT; k++) begin
      kw_ok = (int'(KW_LEN[k]) <= WINDOW_BYTES);
      for (int j = 0; j < KW_MAX_LEN; j++) begin
        if ((j < int'(KW_LEN[k])) && (win_sh[WINDOW_BYTES-1-j] != KW_TEXT[k][8*j +: 8])) begin
          kw_ok = 1'b0;
        end
      end
      hit = hit | kw_ok;
    end
  end

  assign room       = (line_length < LEN_LIMIT);
  assign is_newline = (byte_value == NEWLINE_CHAR);
  assign cut_next   = text_cut | (byte_value == NUL_CHAR);
  assign clear_line = step.byte_go & (!room | is_newline);

  assign res.ended   = room & is_newline;
  assign res.matched = room & is_newline & keyword_seen;
  assign res.dropped = !room;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_length  <= '0;
      text_cut     <= 1'b0;
      keyword_seen <= 1'b0;
    end else if (clear_line) begin
      line_length  <= '0;
      text_cut     <= 1'b0;
      keyword_seen <= 1'b0;
    end else if (step.byte_go) begin
      line_length <= line_length + 1'b1;
      text_cut    <= cut_next;
      if (!cut_next && hit) begin
        keyword_seen <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear_line) begin
      for (int i = 0; i < WINDOW_BYTES; i++) begin
        win[i] <= '0;
      end
    end else if (step.byte_go && !cut_next) begin
      win <= win_sh;
    end
  end

endmodule

`default_nettype wire

// ----- src/kla_alarm.sv -----
// Buzzer and mute control with saturating millisecond counters.
// Depends on kla_pkg for the step, line result and alarm result structs.
`default_nettype none

module kla_alarm
  import kla_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire step_t       step,
  input  wire logic        button_pressed,
  input  wire line_res_t   line_res,
  input  wire logic [15:0] buzz_ms,
  input  wire logic [15:0] mute_ms,
  output alarm_res_t       res
);

  logic        buzzer_active;
  logic        buzzer_pin;
  logic        muted_flag;
  logic [15:0] buzz_elapsed;
  logic [15:0] mute_elapsed;

  logic        buzzer_active_next;
  logic        buzzer_pin_next;
  logic        muted_flag_next;
  logic [15:0] buzz_elapsed_next;
  logic [15:0] mute_elapsed_next;
  logic        started;

  always_comb begin
    buzzer_active_next = buzzer_active;
    buzzer_pin_next    = buzzer_pin;
    muted_flag_next    = muted_flag;
    buzz_elapsed_next  = buzz_elapsed;
    mute_elapsed_next  = mute_elapsed;
    started            = 1'b0;
    if (step.tick_go) begin
      buzz_elapsed_next = (buzz_elapsed == ELAPSED_MAX) ? buzz_elapsed : buzz_elapsed + 16'd1;
      mute_elapsed_next = (mute_elapsed == ELAPSED_MAX) ? mute_elapsed : mute_elapsed + 16'd1;
      if (button_pressed && !muted_flag) begin
        muted_flag_next   = 1'b1;
        mute_elapsed_next = '0;
        buzzer_pin_next   = 1'b0;
      end
      if (muted_flag_next && (mute_elapsed_next >= mute_ms)) begin
        muted_flag_next = 1'b0;
      end
      if (!muted_flag_next && buzzer_active && (buzz_elapsed_next >= buzz_ms)) begin
        buzzer_pin_next    = 1'b0;
        buzzer_active_next = 1'b0;
      end
    end else if (step.byte_go && line_res.matched && !buzzer_active && !muted_flag) begin
      buzzer_pin_next    = 1'b1;
      buzzer_active_next = 1'b1;
      buzz_elapsed_next  = '0;
      started            = 1'b1;
    end
  end

  assign res.pin     = buzzer_pin_next;
  assign res.started = started;
  assign res.muted   = muted_flag_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      buzzer_active <= 1'b0;
      buzzer_pin    <= 1'b0;
      muted_flag    <= 1'b0;
      buzz_elapsed  <= '0;
      mute_elapsed  <= '0;
    end else begin
      buzzer_active <= buzzer_active_next;
      buzzer_pin    <= buzzer_pin_next;
      muted_flag    <= muted_flag_next;
      buzz_elapsed  <= buzz_elapsed_next;
      mute_elapsed  <= mute_elapsed_next;
    end
  end

endmodule

`default_nettype wire

// ----- src/keyword_line_alarm_top.sv -----
// Keyword line alarm top level: input register, line scanner, alarm control, result register.
// An accepted transaction waits in the input register until the result register is free.
// Throughput: one transaction per cycle while out_stall does not hold the result register;
// the keyword compare and timer update sit between the input and result registers.
// Reset (synchronous): clears line, buzzer and mute state; buzz_ms 1000, mute_ms 3000.
`default_nettype none

module keyword_line_alarm_top
  import kla_pkg::*;
#(
  parameter int LINE_MAX     = LINE_MAX_DEF,
  parameter int WINDOW_BYTES = WINDOW_BYTES_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               req_type,
  input  wire logic [7:0]         byte_value,
  input  wire logic               button_pressed,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic                    buzzer_drive,
  output logic                    alarm_started,
  output logic                    line_ended,
  output logic                    line_matched,
  output logic                    mute_active,
  output logic                    line_dropped,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  logic        buzz_ms;
  logic [15:0] buzz_ms_reg;
  logic [15:0] mute_ms_reg;

  logic        in_q_valid;
  logic        q_type;
  logic [7:0]  q_byte;
  logic        q_press;

  logic        out_free;
  logic        move;
  logic        in_accept;
  logic        cfg_write;

  step_t       step;
  line_res_t   line_res;
  alarm_res_t  alarm_res;

  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite;
  assign buzz_ms   = (paddr[2] == REG_BUZZ_MS);
  assign prdata    = buzz_ms ? {16'd0, buzz_ms_reg} : {16'd0, mute_ms_reg};

  always_ff @(posedge clk) begin
    if (rst) begin
      buzz_ms_reg <= BUZZ_MS_RESET;
      mute_ms_reg <= MUTE_MS_RESET;
    end else if (cfg_write) begin
      if (paddr[2] == REG_BUZZ_MS) begin
        buzz_ms_reg <= pwdata[15:0];
      end
      if (paddr[2] == REG_MUTE_MS) begin
        mute_ms_reg <= pwdata[15:0];
      end
    end
  end

  assign out_free  = !out_valid || !out_stall;
  assign move      = in_q_valid && out_free;
  assign in_stall  = in_q_valid && !out_free;
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (in_accept) begin
      in_q_valid <= 1'b1;
    end else if (move) begin
      in_q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      q_type  <= req_type;
      q_byte  <= byte_value;
      q_press <= button_pressed;
    end
  end

  assign step.byte_go = move && !q_type;
  assign step.tick_go = move && q_type;

  kla_line #(
    .LINE_MAX     (LINE_MAX),
    .WINDOW_BYTES (WINDOW_BYTES)
  ) u_line (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .byte_value (q_byte),
    .res        (line_res)
  );

  kla_alarm u_alarm (
    .clk            (clk),
    .rst            (rst),
    .step           (step),
    .button_pressed (q_press),
    .line_res       (line_res),
    .buzz_ms        (buzz_ms_reg),
    .mute_ms        (mute_ms_reg),
    .res            (alarm_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (move) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      buzzer_drive  <= alarm_res.pin;
      alarm_started <= alarm_res.started;
      mute_active   <= alarm_res.muted;
      line_ended    <= !q_type && line_res.ended;
      line_matched  <= !q_type && line_res.matched;
      line_dropped  <= !q_type && line_res.dropped;
    end
  end

  a_start_needs_match: assert property (@(posedge clk) disable iff (rst)
    out_valid && alarm_started |-> line_matched && line_ended && buzzer_drive)
    else $error("alarm start without a matched line end");

  a_match_needs_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && line_matched |-> line_ended && !line_dropped)
    else $error("line match outside a line end");

  a_held_item_kept: assert property (@(posedge clk) disable iff (rst)
    in_q_valid && !out_free |=> in_q_valid)
    else $error("held transaction lost");

  a_move_fills_output: assert property (@(posedge clk) disable iff (rst)
    move |=> out_valid)
    else $error("result register not loaded");

endmodule

`default_nettype wire
